FILE: sv/sdbo_pkg.sv
`default_nettype none
package sdbo_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_TOGGLE  = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // Configuration register indexes (byte address divided by four).
    localparam logic [1:0] REG_POLARITY      = 2'd0;
    localparam logic [1:0] REG_TOGGLE_ACTIVE = 2'd1;
    localparam logic [1:0] REG_ON_DELAY      = 2'd2;
    localparam logic [1:0] REG_OFF_DELAY     = 2'd3;

    localparam int CFG_DELAY_BITS = 16;
    localparam int ADDR_BITS      = 4;
    localparam int COUNT_BITS     = 8;

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [CFG_DELAY_BITS-1:0] t_cfg_delay;

endpackage
`default_nettype wire

FILE: sv/shared_deferred_binary_output.sv
// A word accepted into the input register is worked on there, and its result is then
// written to the result register, which presents it on the output until it is taken.
// Throughput: one word per cycle; o_ready follows i_ready combinationally when both
// registers are full, so only the output side taking results limits the rate.
// Reset: synchronous, active low; clears the pipeline valid flags, the output state,
// the consumer count, the deferred timer and all configuration registers.
`default_nettype none
module shared_deferred_binary_output #(
    parameter int CONSUMER_MAX = 255,
    parameter int DELAY_BITS   = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [sdbo_pkg::ADDR_BITS-1:0]        paddr,
    input  wire logic [31:0]                           pwdata,
    output logic      [31:0]                           prdata,
    output logic                                       pready,
    // input channel
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic [1:0]                            i_op,
    input  wire logic                                  i_value,
    // output channel
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic                                       o_logical_level,
    output logic                                       o_pin_level,
    output logic                                       o_set_strobe,
    output logic                                       o_change_strobe,
    output logic      [sdbo_pkg::COUNT_BITS-1:0]       o_consumer_level,
    output logic                                       o_pending
);

    localparam int WideBits = (DELAY_BITS > sdbo_pkg::CFG_DELAY_BITS) ?
                              DELAY_BITS : sdbo_pkg::CFG_DELAY_BITS;

    // configuration
    logic                       r_polarity;
    logic                       r_toggle_active;
    sdbo_pkg::t_cfg_delay       r_on_delay;
    sdbo_pkg::t_cfg_delay       r_off_delay;
    logic                       cfg_wr;
    logic [1:0]                 cfg_idx;

    // input register
    logic                       r_in_vld;
    logic [1:0]                 r_in_op;
    logic                       r_in_value;
    logic                       advance;

    // state
    logic                       r_logical, n_logical;
    sdbo_pkg::t_count           r_count, n_count;
    logic [DELAY_BITS-1:0]      r_remaining, n_remaining;
    logic                       r_armed, n_armed;
    logic                       r_deferred, n_deferred;

    // result register
    logic                       r_out_vld;
    logic                       r_out_logical;
    logic                       r_out_set;
    logic                       r_out_change;
    sdbo_pkg::t_count           r_out_count;
    logic                       r_out_pending;

    logic                       apply;
    logic                       apply_val;
    logic                       wrote;
    logic                       changed;
    sdbo_pkg::t_count           count_mid;
    sdbo_pkg::t_cfg_delay       dly;
    logic [WideBits-1:0]        dly_wide;
    logic [WideBits-1:0]        dly_max;
    logic [DELAY_BITS-1:0]      dly_load;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[sdbo_pkg::ADDR_BITS-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polarity      <= 1'b0;
            r_toggle_active <= 1'b0;
            r_on_delay      <= '0;
            r_off_delay     <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                sdbo_pkg::REG_POLARITY:      r_polarity      <= pwdata[0];
                sdbo_pkg::REG_TOGGLE_ACTIVE: r_toggle_active <= pwdata[0];
                sdbo_pkg::REG_ON_DELAY:      r_on_delay      <= pwdata[15:0];
                sdbo_pkg::REG_OFF_DELAY:     r_off_delay     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            sdbo_pkg::REG_POLARITY:      prdata = {31'd0, r_polarity};
            sdbo_pkg::REG_TOGGLE_ACTIVE: prdata = {31'd0, r_toggle_active};
            sdbo_pkg::REG_ON_DELAY:      prdata = {16'd0, r_on_delay};
            sdbo_pkg::REG_OFF_DELAY:     prdata = {16'd0, r_off_delay};
            default:                     prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign advance = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_op    <= i_op;
            r_in_value <= i_value;
        end
    end

    // ---------------- item logic ----------------
    // A delay longer than the counter can hold is loaded as the counter's maximum.
    assign dly      = r_in_value ? r_on_delay : r_off_delay;
    assign dly_wide = WideBits'(dly);
    assign dly_max  = WideBits'({DELAY_BITS{1'b1}});
    assign dly_load = (dly_wide > dly_max) ? DELAY_BITS'(dly_max) : DELAY_BITS'(dly_wide);

    assign count_mid = (!r_in_value && r_count != '0) ? r_count - 1'b1 : r_count;

    always_comb begin
        n_logical   = r_logical;
        n_count     = r_count;
        n_remaining = r_remaining;
        n_armed     = r_armed;
        n_deferred  = r_deferred;
        apply       = 1'b0;
        apply_val   = 1'b0;
        wrote       = 1'b0;
        changed     = 1'b0;
        unique case (r_in_op)
            sdbo_pkg::OP_REQUEST: begin
                if (count_mid == '0) begin
                    if (dly != '0) begin
                        n_deferred  = r_in_value;
                        n_remaining = dly_load;
                        n_armed     = 1'b1;
                    end else begin
                        n_armed   = 1'b0;
                        apply     = 1'b1;
                        apply_val = r_in_value;
                    end
                end
                if (r_in_value && count_mid < sdbo_pkg::COUNT_BITS'(CONSUMER_MAX)) begin
                    n_count = count_mid + 1'b1;
                end else begin
                    n_count = count_mid;
                end
            end
            sdbo_pkg::OP_TOGGLE: begin
                if (r_in_value == r_toggle_active) begin
                    apply     = 1'b1;
                    apply_val = !r_logical;
                end
            end
            sdbo_pkg::OP_TICK: begin
                if (r_armed) begin
                    if (r_remaining <= DELAY_BITS'(1)) begin
                        n_remaining = '0;
                        n_armed     = 1'b0;
                        apply       = 1'b1;
                        apply_val   = r_deferred;
                    end else begin
                        n_remaining = r_remaining - 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (apply) begin
            n_logical = apply_val;
            wrote     = 1'b1;
            changed   = (apply_val != r_logical);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_logical   <= 1'b0;
            r_count     <= '0;
            r_remaining <= '0;
            r_armed     <= 1'b0;
            r_deferred  <= 1'b0;
        end else if (advance) begin
            r_logical   <= n_logical;
            r_count     <= n_count;
            r_remaining <= n_remaining;
            r_armed     <= n_armed;
            r_deferred  <= n_deferred;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_logical <= n_logical;
            r_out_set     <= wrote;
            r_out_change  <= changed;
            r_out_count   <= n_count;
            r_out_pending <= n_armed;
        end
    end

    assign o_valid          = r_out_vld;
    assign o_logical_level  = r_out_logical;
    // The pin sits at the polarity level when the output is logically true.
    assign o_pin_level      = !(r_out_logical ^ r_polarity);
    assign o_set_strobe     = r_out_set;
    assign o_change_strobe  = r_out_change;
    assign o_consumer_level = r_out_count;
    assign o_pending        = r_out_pending;

endmodule
`default_nettype wire

FILE: sv/sdbo_checker.sv
`default_nettype none
module sdbo_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                o_valid,
    input wire logic                                i_ready,
    input wire logic                                o_logical_level,
    input wire logic                                o_set_strobe,
    input wire logic                                o_change_strobe,
    input wire logic [sdbo_pkg::COUNT_BITS-1:0]     o_consumer_level
);

    // Nothing is presented on the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result word presented straight after reset");

    // A level change can only come from a write to the output.
    a_change_needs_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_change_strobe |-> o_set_strobe)
        else $error("change strobe without set strobe");

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_logical_level)
            && $stable(o_consumer_level) && $stable(o_set_strobe))
        else $error("result word changed while stalled");

endmodule

bind shared_deferred_binary_output sdbo_checker u_sdbo_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_logical_level  (o_logical_level),
    .o_set_strobe     (o_set_strobe),
    .o_change_strobe  (o_change_strobe),
    .o_consumer_level (o_consumer_level)
);
`default_nettype wire

FILE: tb/shared_deferred_binary_output_tb.sv
`default_nettype none
module shared_deferred_binary_output_tb;

    localparam int CLK_PERIOD   = 12;
    localparam int CONSUMER_MAX = 255;
    localparam int DELAY_BITS   = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int LONG_HOLD_CYCLES  = 80;

    typedef struct packed {
        logic             logical;
        logic             pin;
        logic             wrote;
        logic             changed;
        sdbo_pkg::t_count consumers;
        logic             pending;
    } t_level_report;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [sdbo_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_op = sdbo_pkg::OP_TICK;
    logic i_value = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_logical_level;
    logic o_pin_level;
    logic o_set_strobe;
    logic o_change_strobe;
    sdbo_pkg::t_count o_consumer_level;
    logic o_pending;

    shared_deferred_binary_output #(
        .CONSUMER_MAX(CONSUMER_MAX),
        .DELAY_BITS  (DELAY_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_logical_level (o_logical_level),
        .o_pin_level     (o_pin_level),
        .o_set_strobe    (o_set_strobe),
        .o_change_strobe (o_change_strobe),
        .o_consumer_level(o_consumer_level),
        .o_pending       (o_pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the output's configuration and state.
    logic                 cfg_polarity = 1'b0;
    logic                 cfg_toggle_level = 1'b0;
    sdbo_pkg::t_cfg_delay cfg_on_delay = '0;
    sdbo_pkg::t_cfg_delay cfg_off_delay = '0;
    logic                 out_level = 1'b0;
    sdbo_pkg::t_count     consumer_cnt = '0;
    sdbo_pkg::t_cfg_delay ticks_left = '0;
    logic                 timer_run = 1'b0;
    logic                 held_level = 1'b0;
    logic                 step_wrote;
    logic                 step_changed;

    t_level_report level_reports_due[$];

    int  mismatches = 0;
    int  words_in = 0;
    int  results_seen = 0;
    int  expiries = 0;
    int  toggles_applied = 0;
    int  consumer_peak = 0;
    int  input_stall_cycles = 0;
    bit  tx_gaps = 1'b0;
    bit  rx_gaps = 1'b0;
    bit  long_hold_req = 1'b0;

    function automatic void drive_level(logic v);
        step_wrote = 1'b1;
        if (v != out_level) step_changed = 1'b1;
        out_level = v;
    endfunction

    function automatic t_level_report predict_level(logic [1:0] op, logic val);
        t_level_report r;
        sdbo_pkg::t_cfg_delay dly;
        step_wrote = 1'b0;
        step_changed = 1'b0;
        case (op)
            sdbo_pkg::OP_REQUEST: begin
                dly = val ? cfg_on_delay : cfg_off_delay;
                if (!val && consumer_cnt != 0) consumer_cnt = consumer_cnt - 1'b1;
                if (consumer_cnt == 0) begin
                    if (dly != 0) begin
                        held_level = val;
                        ticks_left = dly;
                        timer_run = 1'b1;
                    end else begin
                        timer_run = 1'b0;
                        drive_level(val);
                    end
                end
                if (val && consumer_cnt < CONSUMER_MAX) consumer_cnt = consumer_cnt + 1'b1;
            end
            sdbo_pkg::OP_TOGGLE: begin
                if (val == cfg_toggle_level) begin
                    drive_level(~out_level);
                    toggles_applied++;
                end
            end
            sdbo_pkg::OP_TICK: begin
                if (timer_run) begin
                    if (ticks_left <= 1) begin
                        ticks_left = '0;
                        timer_run = 1'b0;
                        drive_level(held_level);
                        expiries++;
                    end else begin
                        ticks_left = ticks_left - 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (consumer_cnt > consumer_peak) consumer_peak = consumer_cnt;
        r.logical   = out_level;
        r.pin       = out_level ? cfg_polarity : ~cfg_polarity;
        r.wrote     = step_wrote;
        r.changed   = step_changed;
        r.consumers = consumer_cnt;
        r.pending   = timer_run;
        return r;
    endfunction

    function automatic string show_report(t_level_report r);
        return $sformatf("logical=%0b pin=%0b set=%0b change=%0b consumers=%0d pending=%0b",
                         r.logical, r.pin, r.wrote, r.changed, r.consumers, r.pending);
    endfunction

    // Prediction on input acceptance, comparison on output acceptance.
    always @(posedge i_clk) begin : result_check
        t_level_report want;
        t_level_report got;
        if (i_rst_n) begin
            if (i_valid && !o_ready) input_stall_cycles++;
            if (i_valid && o_ready) begin
                level_reports_due.push_back(predict_level(i_op, i_value));
                words_in++;
            end
            if (o_valid && i_ready) begin
                got = '{o_logical_level, o_pin_level, o_set_strobe, o_change_strobe,
                        o_consumer_level, o_pending};
                results_seen++;
                if (level_reports_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with none due: %s",
                                 results_seen, show_report(got));
                end else begin
                    want = level_reports_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result %0d mismatch", results_seen);
                            $display("  expected %s", show_report(want));
                            $display("  actual   %s", show_report(got));
                        end
                    end
                end
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin : result_receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD_CYCLES - 1;
                i_ready = 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                i_ready = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 4);
                i_ready = 1'b0;
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken,
    // leaving valid high so that a following word can go straight out.
    task automatic send_word(logic [1:0] op, logic val);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_op = op;
        i_value = val;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid = 1'b0;
        while (level_reports_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            sdbo_pkg::REG_POLARITY:      cfg_polarity = data[0];
            sdbo_pkg::REG_TOGGLE_ACTIVE: cfg_toggle_level = data[0];
            sdbo_pkg::REG_ON_DELAY:      cfg_on_delay = data[sdbo_pkg::CFG_DELAY_BITS-1:0];
            sdbo_pkg::REG_OFF_DELAY:     cfg_off_delay = data[sdbo_pkg::CFG_DELAY_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic pol, logic tgl, sdbo_pkg::t_cfg_delay on_dly,
                              sdbo_pkg::t_cfg_delay off_dly);
        settle();
        write_reg(sdbo_pkg::REG_POLARITY, {31'd0, pol});
        write_reg(sdbo_pkg::REG_TOGGLE_ACTIVE, {31'd0, tgl});
        write_reg(sdbo_pkg::REG_ON_DELAY, {16'd0, on_dly});
        write_reg(sdbo_pkg::REG_OFF_DELAY, {16'd0, off_dly});
    endtask

    // Reset values: immediate requests, toggles on a low input, idle ticks, unused op.
    task automatic test_immediate_requests();
        send_word(sdbo_pkg::OP_TICK, 1'b0);
        send_word(OP_UNUSED, 1'b1);
        send_word(sdbo_pkg::OP_REQUEST, 1'b0);
        send_word(sdbo_pkg::OP_TOGGLE, 1'b0);
        send_word(sdbo_pkg::OP_TOGGLE, 1'b1);
        send_word(sdbo_pkg::OP_REQUEST, 1'b1);
        send_word(sdbo_pkg::OP_REQUEST, 1'b1);
        send_word(sdbo_pkg::OP_REQUEST, 1'b0);
        send_word(sdbo_pkg::OP_REQUEST, 1'b0);
        send_word(sdbo_pkg::OP_REQUEST, 1'b0);
        send_word(OP_UNUSED, 1'b0);
    endtask

    task automatic test_polarity_and_toggle();
        set_config(1'b1, 1'b1, '0, '0);
        send_word(sdbo_pkg::OP_TOGGLE, 1'b1);
        send_word(sdbo_pkg::OP_TOGGLE, 1'b0);
        send_word(sdbo_pkg::OP_TOGGLE, 1'b1);
        send_word(sdbo_pkg::OP_REQUEST, 1'b1);
        send_word(sdbo_pkg::OP_TOGGLE, 1'b1);
        send_word(sdbo_pkg::OP_REQUEST, 1'b0);
    endtask

    // Deferred values: expiry, toggle while pending, restart, delay of one, widest delay.
    task automatic test_deferred_levels();
        set_config(1'b0, 1'b0, 16'd3, 16'd2);
        send_word(sdbo_pkg::OP_REQUEST, 1'b1);
        send_word(sdbo_pkg::OP_TICK, 1'b0);
        send_word(sdbo_pkg::OP_TOGGLE, 1'b0);
        send_word(sdbo_pkg::OP_TICK, 1'b1);
        send_word(sdbo_pkg::OP_TICK, 1'b0);
        send_word(sdbo_pkg::OP_TICK, 1'b0);
        send_word(sdbo_pkg::OP_REQUEST, 1'b0);
        send_word(sdbo_pkg::OP_TICK, 1'b0);
        send_word(sdbo_pkg::OP_REQUEST, 1'b1);
        repeat (3) send_word(sdbo_pkg::OP_TICK, 1'b0);
        send_word(sdbo_pkg::OP_REQUEST, 1'b0);
        repeat (2) send_word(sdbo_pkg::OP_TICK, 1'b0);
        set_config(1'b1, 1'b0, 16'd1, 16'hFFFF);
        send_word(sdbo_pkg::OP_REQUEST, 1'b1);
        send_word(sdbo_pkg::OP_TICK, 1'b0);
        send_word(sdbo_pkg::OP_REQUEST, 1'b0);
        repeat (3) send_word(sdbo_pkg::OP_TICK, 1'b0);
        set_config(1'b0, 1'b1, 16'hFFFF, 16'd0);
        send_word(sdbo_pkg::OP_REQUEST, 1'b1);
        repeat (2) send_word(sdbo_pkg::OP_TICK, 1'b0);
        send_word(sdbo_pkg::OP_REQUEST, 1'b0);
        send_word(sdbo_pkg::OP_TICK, 1'b0);
    endtask

    task automatic test_consumer_saturation();
        set_config(1'b0, 1'b0, '0, '0);
        repeat (CONSUMER_MAX + 5) send_word(sdbo_pkg::OP_REQUEST, 1'b1);
        repeat (CONSUMER_MAX + 3) send_word(sdbo_pkg::OP_REQUEST, 1'b0);
    endtask

    // The receiver holds off while words keep coming, so the input side must stall.
    task automatic test_output_backpressure();
        settle();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        long_hold_req = 1'b1;
        repeat (30) send_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_random_phase(int words, logic pol, logic tgl,
                                    sdbo_pkg::t_cfg_delay on_dly,
                                    sdbo_pkg::t_cfg_delay off_dly, bit gaps);
        int pick;
        logic [1:0] op;
        set_config(pol, tgl, on_dly, off_dly);
        tx_gaps = gaps;
        rx_gaps = gaps;
        repeat (words) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      op = sdbo_pkg::OP_REQUEST;
            else if (pick < 78) op = sdbo_pkg::OP_TICK;
            else if (pick < 94) op = sdbo_pkg::OP_TOGGLE;
            else                op = OP_UNUSED;
            send_word(op, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : run_length_guard
        #(CLK_PERIOD * 400000);
        $display("FAIL shared_deferred_binary_output");
        $finish;
    end

    initial begin : test_sequence
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        test_immediate_requests();
        test_polarity_and_toggle();
        test_deferred_levels();
        test_consumer_saturation();
        test_output_backpressure();
        run_random_phase(100, 1'b1, 1'b0, 16'($urandom_range(1, 4)),
                         16'($urandom_range(1, 4)), 1'b1);
        run_random_phase(100, 1'b0, 1'b1, 16'd0, 16'($urandom_range(1, 6)), 1'b1);
        run_random_phase(100, 1'b1, 1'b1, 16'($urandom_range(1, 6)), 16'd0, 1'b1);
        run_random_phase(100, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b1);
        run_random_phase(100, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1);
        // Closing stretch runs at full rate with no idling on either side.
        run_random_phase(100, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)), 1'b0);
        settle();
        repeat (10) @(posedge i_clk);
        $display("Run covered %0d words and %0d results: %0d deferred expiries, %0d toggles,",
                 words_in, results_seen, expiries, toggles_applied);
        $display("consumer count peak %0d, %0d cycles of input stall, %0d mismatches.",
                 consumer_peak, input_stall_cycles, mismatches);
        if (mismatches == 0 && level_reports_due.size() == 0) begin
            $display("PASS shared_deferred_binary_output");
        end else begin
            $display("FAIL shared_deferred_binary_output");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
sv/sdbo_pkg.sv
sv/shared_deferred_binary_output.sv
sv/sdbo_checker.sv
tb/shared_deferred_binary_output_tb.sv
